@@ sv/iltm_pkg.sv @@
`timescale 1ns / 1ps

package iltm_pkg;

  localparam int unsigned MAX_CHARS   = 199;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CHAR_W  = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned TOKEN_W = 7;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned DIGIT_W = 4;
  // Room for magnitude * 10 + 9 with the magnitude held at or below 2^31.
  localparam int unsigned ACC_W   = 36;

  localparam logic [CHAR_W-1:0] CH_NUL   = 16'd0;
  localparam logic [CHAR_W-1:0] CH_TAB   = 16'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 16'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 16'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 16'd43;
  localparam logic [CHAR_W-1:0] CH_COMMA = 16'd44;
  localparam logic [CHAR_W-1:0] CH_MINUS = 16'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'd57;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 16'd59;

  localparam logic [VALUE_W-1:0] MAG_CAP = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] MAX_POS = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLOSE,
    OP_BLANK,
    OP_MINUS,
    OP_PLUS,
    OP_DIGIT,
    OP_OTHER
  } op_e;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_STOP
  } phase_e;

  typedef struct packed {
    op_e                op;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } cmd_t;

endpackage

@@ sv/iltm_char_if.sv @@
`timescale 1ns / 1ps

interface iltm_char_if;
  logic                        valid;
  logic                        ready;
  logic [iltm_pkg::CHAR_W-1:0] char_code;
  logic                        is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

@@ sv/iltm_res_if.sv @@
`timescale 1ns / 1ps

interface iltm_res_if;
  logic                              valid;
  logic                              ready;
  logic                              match_found;
  logic signed [iltm_pkg::POS_W-1:0] match_position;

  modport source (output valid, output match_found, output match_position, input ready);
  modport sink   (input valid, input match_found, input match_position, output ready);
endinterface

@@ sv/int_list_token_match_top.sv @@
`timescale 1ns / 1ps

// Finds a search value in a list of decimal integers that arrives one 16-bit
// character per beat, and returns the 0-based position of the first matching
// token (or -1) on a single result beat after the character flagged is_last.
// Characters are taken at one per cycle while the queue has room: the front
// end classifies each character as it is accepted, a two-entry queue holds
// the classified characters, and the back end runs the multiply-by-ten
// accumulate and the token compare for one character per cycle unless a
// list end is held back. A list end loads the result register as it leaves
// the queue. A waiting result stalls only a second list end, not the next
// list's characters. The user must write search_value (search_value_we_i /
// search_value_i) only while no list is in flight; the block does not check.
module int_list_token_match_top #(
  parameter int unsigned MaxChars = iltm_pkg::MAX_CHARS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         search_value_we_i,
  input  logic [iltm_pkg::VALUE_W-1:0] search_value_i,
  iltm_char_if.sink                    chr_i,
  iltm_res_if.source                   res_o
);

  iltm_pkg::cmd_t front_cmd;
  logic           front_valid;
  logic           front_ready;
  iltm_pkg::cmd_t back_cmd;
  logic           back_valid;
  logic           back_ready;
  logic           back_pop;

  iltm_front #(
    .MaxChars (MaxChars)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chr_i       (chr_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  iltm_queue #(
    .Depth (iltm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  iltm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .search_value_we_i (search_value_we_i),
    .search_value_i    (search_value_i),
    .cmd_i             (back_cmd),
    .cmd_valid_i       (back_valid),
    .cmd_ready_o       (back_ready),
    .pop_o             (back_pop),
    .res_o             (res_o)
  );

`ifndef SYNTHESIS
  // A result beat only appears right after a list end left the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(back_pop && back_cmd.last))
    else $error("result appeared without a list end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.match_found) |-> (res_o.match_position == '1))
    else $error("no match but position is not -1");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.match_found) |-> !res_o.match_position[iltm_pkg::POS_W-1])
    else $error("match reported with a negative position");
`endif

endmodule

@@ sv/iltm_front.sv @@
`timescale 1ns / 1ps

module iltm_front #(
  parameter int unsigned MaxChars = iltm_pkg::MAX_CHARS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  iltm_char_if.sink         chr_i,
  output iltm_pkg::cmd_t    cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i
);

  localparam int unsigned CntW = $clog2(MaxChars + 1);

  logic [CntW-1:0] taken_q, taken_d;
  logic            ended_q, ended_d;
  logic            counting;
  logic            accept;
  iltm_pkg::op_e   op;

  assign chr_i.ready = cmd_ready_i;
  assign cmd_valid_o = chr_i.valid;
  assign accept      = chr_i.valid && cmd_ready_i;
  assign counting    = !ended_q && (taken_q < CntW'(MaxChars));

  always_comb begin
    if (!counting) begin
      op = iltm_pkg::OP_NONE;
    end else if (chr_i.char_code inside {iltm_pkg::CH_NUL, iltm_pkg::CH_TAB,
                                         iltm_pkg::CH_SPACE, iltm_pkg::CH_COMMA,
                                         iltm_pkg::CH_SEMI}) begin
      op = iltm_pkg::OP_CLOSE;
    end else if (chr_i.char_code inside {[iltm_pkg::CH_LF:iltm_pkg::CH_CR]}) begin
      op = iltm_pkg::OP_BLANK;
    end else if (chr_i.char_code == iltm_pkg::CH_MINUS) begin
      op = iltm_pkg::OP_MINUS;
    end else if (chr_i.char_code == iltm_pkg::CH_PLUS) begin
      op = iltm_pkg::OP_PLUS;
    end else if (chr_i.char_code inside {[iltm_pkg::CH_ZERO:iltm_pkg::CH_NINE]}) begin
      op = iltm_pkg::OP_DIGIT;
    end else begin
      op = iltm_pkg::OP_OTHER;
    end
  end

  always_comb begin
    cmd_o.op    = op;
    cmd_o.digit = chr_i.char_code[iltm_pkg::DIGIT_W-1:0];
    cmd_o.last  = chr_i.is_last;
  end

  always_comb begin
    taken_d = taken_q;
    ended_d = ended_q;
    if (accept) begin
      if (chr_i.is_last) begin
        taken_d = '0;
        ended_d = 1'b0;
      end else if (counting) begin
        if (chr_i.char_code == iltm_pkg::CH_NUL) begin
          ended_d = 1'b1;
        end else begin
          taken_d = taken_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
      ended_q <= 1'b0;
    end else begin
      taken_q <= taken_d;
      ended_q <= ended_d;
    end
  end

endmodule

@@ sv/iltm_queue.sv @@
`timescale 1ns / 1ps

module iltm_queue #(
  parameter int unsigned Depth = iltm_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  iltm_pkg::cmd_t push_data_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output iltm_pkg::cmd_t pop_data_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  iltm_pkg::cmd_t  slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/iltm_back.sv @@
`timescale 1ns / 1ps

module iltm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          search_value_we_i,
  input  logic [iltm_pkg::VALUE_W-1:0]  search_value_i,
  input  iltm_pkg::cmd_t                cmd_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  output logic                          pop_o,
  iltm_res_if.source                    res_o
);

  localparam int unsigned VW = iltm_pkg::VALUE_W;
  localparam int unsigned TW = iltm_pkg::TOKEN_W;
  localparam int unsigned AW = iltm_pkg::ACC_W;

  logic [VW-1:0]     search_q;
  logic [VW-1:0]     neg_target;

  logic              inside_q, inside_d;
  iltm_pkg::phase_e  phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [VW-1:0]     mag_q, mag_d;
  logic [TW-1:0]     count_q, count_d;
  logic              found_q, found_d;
  logic [TW-1:0]     index_q, index_d;

  logic              res_valid_q, res_valid_d;
  logic              res_found_q;
  logic [iltm_pkg::POS_W-1:0] res_pos_q;

  logic [AW-1:0]     acc;
  logic [VW-1:0]     mag_acc;
  logic              pop, res_load;

  // A list end may only leave the queue when the result register can take it.
  assign cmd_ready_o = !(cmd_i.last && res_valid_q && !res_o.ready);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign pop_o       = pop;
  assign res_load    = pop && cmd_i.last;
  assign neg_target  = '0 - search_q;

  assign acc     = (AW'(mag_q) << 3) + (AW'(mag_q) << 1) + AW'(cmd_i.digit);
  assign mag_acc = (acc > AW'(iltm_pkg::MAG_CAP)) ? iltm_pkg::MAG_CAP : acc[VW-1:0];

  always_comb begin
    logic             inside_m;
    logic             neg_m;
    logic [VW-1:0]    mag_m;
    iltm_pkg::phase_e phase_m;
    logic             hit;

    inside_m = inside_q;
    neg_m    = neg_q;
    mag_m    = mag_q;
    phase_m  = phase_q;

    inside_d = inside_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    count_d  = count_q;
    found_d  = found_q;
    index_d  = index_q;
    hit      = 1'b0;

    case (cmd_i.op)
      iltm_pkg::OP_NONE, iltm_pkg::OP_CLOSE: begin
      end
      default: begin
        inside_m = 1'b1;
        case (phase_q)
          iltm_pkg::PH_LEAD: begin
            case (cmd_i.op)
              iltm_pkg::OP_BLANK: begin
              end
              iltm_pkg::OP_MINUS: begin
                phase_m = iltm_pkg::PH_DIGITS;
                neg_m   = 1'b1;
              end
              iltm_pkg::OP_PLUS: begin
                phase_m = iltm_pkg::PH_DIGITS;
              end
              iltm_pkg::OP_DIGIT: begin
                phase_m = iltm_pkg::PH_DIGITS;
                mag_m   = mag_acc;
              end
              default: begin
                phase_m = iltm_pkg::PH_STOP;
              end
            endcase
          end
          iltm_pkg::PH_DIGITS: begin
            if (cmd_i.op == iltm_pkg::OP_DIGIT) begin
              mag_m = mag_acc;
            end else begin
              phase_m = iltm_pkg::PH_STOP;
            end
          end
          default: begin
          end
        endcase
      end
    endcase

    // The saturated positive value equals the search value either directly or,
    // for a magnitude held at 2^31, when the search value is the largest int.
    if (neg_m) begin
      hit = (mag_m == neg_target);
    end else if (mag_m == iltm_pkg::MAG_CAP) begin
      hit = (search_q == iltm_pkg::MAX_POS);
    end else begin
      hit = (mag_m == search_q);
    end

    if (pop) begin
      inside_d = inside_m;
      phase_d  = phase_m;
      neg_d    = neg_m;
      mag_d    = mag_m;
      if ((cmd_i.op == iltm_pkg::OP_CLOSE || cmd_i.last) && inside_m) begin
        if (!found_q && hit) begin
          found_d = 1'b1;
          index_d = count_q;
        end
        if (count_q != '1) begin
          count_d = count_q + TW'(1);
        end
        inside_d = 1'b0;
        phase_d  = iltm_pkg::PH_LEAD;
        neg_d    = 1'b0;
        mag_d    = '0;
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.match_found    = res_found_q;
  assign res_o.match_position = res_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_q    <= '0;
      inside_q    <= 1'b0;
      phase_q     <= iltm_pkg::PH_LEAD;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      index_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (search_value_we_i) begin
        search_q <= search_value_i;
      end
      res_valid_q <= res_valid_d;
      if (res_load) begin
        inside_q <= 1'b0;
        phase_q  <= iltm_pkg::PH_LEAD;
        neg_q    <= 1'b0;
        mag_q    <= '0;
        count_q  <= '0;
        found_q  <= 1'b0;
        index_q  <= '0;
      end else begin
        inside_q <= inside_d;
        phase_q  <= phase_d;
        neg_q    <= neg_d;
        mag_q    <= mag_d;
        count_q  <= count_d;
        found_q  <= found_d;
        index_q  <= index_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_found_q <= found_d;
      res_pos_q   <= found_d ? {1'b0, index_d} : '1;
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  typedef logic [iltm_pkg::CHAR_W-1:0] text_t[$];

  typedef struct packed {
    logic                             found;
    logic signed [iltm_pkg::POS_W-1:0] pos;
  } match_t;

  localparam int ITEM_GOAL = 1750;
  localparam int CALM_TAIL = 250;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         search_value_we;
  logic [iltm_pkg::VALUE_W-1:0] search_value;

  iltm_char_if chr ();
  iltm_res_if  res ();

  int_list_token_match_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .search_value_we_i (search_value_we),
    .search_value_i    (search_value),
    .chr_i             (chr),
    .res_o             (res)
  );

  always #5 clk_i = ~clk_i;

  // Scanner state kept alongside the block.
  logic [iltm_pkg::VALUE_W-1:0] want_value;
  logic [7:0]                   n_taken;
  bit                           text_done;
  bit                           in_token;
  iltm_pkg::phase_e             phase;
  bit                           negative;
  logic [iltm_pkg::VALUE_W-1:0] mag;
  logic [iltm_pkg::TOKEN_W-1:0] n_tokens;
  bit                           hit;
  logic [iltm_pkg::TOKEN_W-1:0] hit_index;

  match_t expected_matches[$];
  text_t  list_buf;

  bit idling_on = 1'b1;
  int chars_sent, lists_sent, results_seen, matches_seen, n_settings, errors;

  function automatic void clear_scan();
    n_taken   = '0;
    text_done = 1'b0;
    in_token  = 1'b0;
    phase     = iltm_pkg::PH_LEAD;
    negative  = 1'b0;
    mag       = '0;
    n_tokens  = '0;
    hit       = 1'b0;
    hit_index = '0;
  endfunction

  function automatic bit is_sep(logic [iltm_pkg::CHAR_W-1:0] c);
    return c == iltm_pkg::CH_SPACE || c == iltm_pkg::CH_COMMA ||
           c == iltm_pkg::CH_SEMI || c == iltm_pkg::CH_TAB;
  endfunction

  function automatic void end_token();
    logic [iltm_pkg::VALUE_W-1:0] value;
    if (!in_token) return;
    value = negative ? (~mag + 1'b1) :
            ((mag > iltm_pkg::MAX_POS) ? iltm_pkg::MAX_POS : mag);
    if (!hit && value == want_value) begin
      hit       = 1'b1;
      hit_index = n_tokens;
    end
    if (n_tokens != '1) n_tokens++;
    in_token = 1'b0;
    phase    = iltm_pkg::PH_LEAD;
    negative = 1'b0;
    mag      = '0;
  endfunction

  function automatic void scan_char(logic [iltm_pkg::CHAR_W-1:0] c);
    logic [iltm_pkg::ACC_W-1:0] acc;
    if (is_sep(c)) begin
      end_token();
      return;
    end
    in_token = 1'b1;
    if (phase == iltm_pkg::PH_LEAD) begin
      if (c == iltm_pkg::CH_SPACE || (c >= iltm_pkg::CH_TAB && c <= iltm_pkg::CH_CR)) return;
      phase = iltm_pkg::PH_DIGITS;
      if (c == iltm_pkg::CH_MINUS) begin
        negative = 1'b1;
        return;
      end
      if (c == iltm_pkg::CH_PLUS) return;
    end
    if (phase == iltm_pkg::PH_DIGITS) begin
      if (c >= iltm_pkg::CH_ZERO && c <= iltm_pkg::CH_NINE) begin
        acc = iltm_pkg::ACC_W'(mag) * 10 + iltm_pkg::ACC_W'(c - iltm_pkg::CH_ZERO);
        mag = (acc > iltm_pkg::ACC_W'(iltm_pkg::MAG_CAP)) ?
              iltm_pkg::MAG_CAP : acc[iltm_pkg::VALUE_W-1:0];
      end else begin
        phase = iltm_pkg::PH_STOP;
      end
    end
  endfunction

  function automatic void predict_beat(logic [iltm_pkg::CHAR_W-1:0] c, logic last);
    match_t m;
    if (!text_done && n_taken < iltm_pkg::MAX_CHARS) begin
      if (c == iltm_pkg::CH_NUL) begin
        text_done = 1'b1;
        end_token();
      end else begin
        scan_char(c);
        n_taken++;
      end
    end
    if (last) begin
      end_token();
      m.found = hit;
      m.pos   = hit ? iltm_pkg::POS_W'({1'b0, hit_index}) : '1;
      expected_matches.push_back(m);
      clear_scan();
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    match_t want;
    if (rst_ni) begin
      if (chr.valid && chr.ready) predict_beat(chr.char_code, chr.is_last);
      if (res.valid && res.ready) begin
        results_seen++;
        if (expected_matches.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("tb_top: unexpected result beat found=%0b pos=%0d at %0t",
                     res.match_found, res.match_position, $realtime);
        end else begin
          want = expected_matches.pop_front();
          if (want.found) matches_seen++;
          if (res.match_found !== want.found || res.match_position !== want.pos) begin
            errors++;
            if (errors <= 10)
              $display({"tb_top: mismatch at %0t: expected found=%0b pos=%0d, ",
                        "got found=%0b pos=%0d"},
                       $realtime, want.found, want.pos, res.match_found,
                       res.match_position);
          end
        end
      end
    end
  end

  // Result side: random stall bursts while idling is on.
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (idling_on && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  task automatic idle_source();
    chr.valid   <= 1'b0;
    chr.is_last <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_beat(logic [iltm_pkg::CHAR_W-1:0] c, logic last);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      chr.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    chr.valid     <= 1'b1;
    chr.char_code <= c;
    chr.is_last   <= last;
    @(posedge clk_i);
    while (!chr.ready) @(posedge clk_i);
    @(negedge clk_i);
    chars_sent++;
  endtask

  task automatic send_list(text_t t);
    foreach (t[i]) send_beat(t[i], i == t.size() - 1);
    lists_sent++;
  endtask

  // Drops the source and waits until every expected result has been checked.
  task automatic wait_idle();
    idle_source();
    while (expected_matches.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_search(logic [iltm_pkg::VALUE_W-1:0] v);
    wait_idle();
    search_value_we <= 1'b1;
    search_value    <= v;
    @(negedge clk_i);
    search_value_we <= 1'b0;
    want_value = v;
    n_settings++;
  endtask

  function automatic void put_str(ref text_t t, input string s);
    foreach (s[i]) t.push_back(iltm_pkg::CHAR_W'(s[i]));
  endfunction

  function automatic void put_num(ref text_t t, input int v, input bit plus);
    if (plus && v >= 0) t.push_back(iltm_pkg::CH_PLUS);
    put_str(t, $sformatf("%0d", v));
  endfunction

  function automatic void put_digits(ref text_t t, input int n);
    repeat (n) t.push_back(iltm_pkg::CH_ZERO + iltm_pkg::CHAR_W'($urandom_range(0, 9)));
  endfunction

  function automatic void put_break(ref text_t t);
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 3))
        0:       t.push_back(iltm_pkg::CH_SPACE);
        1:       t.push_back(iltm_pkg::CH_COMMA);
        2:       t.push_back(iltm_pkg::CH_SEMI);
        default: t.push_back(iltm_pkg::CH_TAB);
      endcase
    end
  endfunction

  function automatic logic [iltm_pkg::CHAR_W-1:0] junk();
    logic [iltm_pkg::CHAR_W-1:0] c;
    do c = iltm_pkg::CHAR_W'($urandom_range(1, 65535));
    while (is_sep(c) || (c >= iltm_pkg::CH_ZERO && c <= iltm_pkg::CH_NINE) ||
           c == iltm_pkg::CH_PLUS || c == iltm_pkg::CH_MINUS);
    return c;
  endfunction

  // Mostly well-formed lists that often contain the searched value, with
  // malformed tokens, early text ends and stray wide characters mixed in.
  function automatic void make_list(ref text_t t);
    int ntok;
    t.delete();
    case ($urandom_range(0, 19))
      0: put_break(t);
      1: t.push_back(iltm_pkg::CH_NUL);
      default: begin
        if ($urandom_range(0, 3) == 0) put_break(t);
        ntok = $urandom_range(1, 7);
        for (int k = 0; k < ntok; k++) begin
          if ($urandom_range(0, 4) == 0)
            t.push_back(iltm_pkg::CHAR_W'($urandom_range(iltm_pkg::CH_LF, iltm_pkg::CH_CR)));
          case ($urandom_range(0, 9))
            0, 1, 2: put_num(t, int'(want_value), 1'($urandom_range(0, 1)));
            3:       put_num(t, int'($urandom_range(0, 1099)) - 99,
                             1'($urandom_range(0, 1)));
            4:       put_num(t, int'($urandom()), 1'($urandom_range(0, 1)));
            5: begin
              if ($urandom_range(0, 1))
                t.push_back($urandom_range(0, 1) ? iltm_pkg::CH_MINUS : iltm_pkg::CH_PLUS);
              put_digits(t, $urandom_range(10, 16));
            end
            6: begin
              if ($urandom_range(0, 1))
                t.push_back($urandom_range(0, 1) ? iltm_pkg::CH_MINUS : iltm_pkg::CH_PLUS);
              else t.push_back(junk());
              if ($urandom_range(0, 1)) put_digits(t, $urandom_range(1, 3));
            end
            7: begin
              put_digits(t, $urandom_range(1, 4));
              t.push_back(junk());
              put_digits(t, $urandom_range(0, 3));
            end
            8: put_num(t, int'(want_value) + ($urandom_range(0, 1) ? 1 : -1), 1'b0);
            default: begin
              t.push_back(iltm_pkg::CH_MINUS);
              t.push_back($urandom_range(0, 1) ? iltm_pkg::CH_MINUS :
                          iltm_pkg::CHAR_W'($urandom_range(iltm_pkg::CH_LF, iltm_pkg::CH_CR)));
              put_digits(t, $urandom_range(1, 3));
            end
          endcase
          if (k != ntok - 1 || $urandom_range(0, 3) == 0) put_break(t);
        end
        if ($urandom_range(0, 9) == 0) begin
          t.push_back(iltm_pkg::CH_NUL);
          repeat ($urandom_range(0, 5)) t.push_back(iltm_pkg::CHAR_W'($urandom()));
        end
      end
    endcase
  endfunction

  task automatic test_extremes();
    text_t t;
    write_search(iltm_pkg::MAG_CAP);
    put_str(t, "\n-99999999999");
    send_list(t);
    t.delete();
    write_search(iltm_pkg::MAX_POS);
    put_str(t, "7;+9999999999");
    send_list(t);
  endtask

  // A sign with no digits, a text end with characters behind it, a lone zero
  // character and a list of nothing but separators.
  task automatic test_special_cases();
    text_t t;
    write_search('0);
    put_str(t, "5 -,x");
    t.push_back(iltm_pkg::CH_NUL);
    t.push_back(iltm_pkg::CH_ZERO + 9);
    send_list(t);
    t.delete();
    t.push_back(iltm_pkg::CH_NUL);
    send_list(t);
    t.delete();
    put_str(t, ",,");
    send_list(t);
  endtask

  // The last counted character falls inside a token; what follows is dropped.
  task automatic test_char_limit();
    text_t t, part;
    repeat (99) put_str(t, "1,");
    put_str(t, "78,7");
    write_search(iltm_pkg::VALUE_W'(7));
    send_list(t);
    write_search(iltm_pkg::VALUE_W'(78));
    send_list(t);
    write_search(iltm_pkg::VALUE_W'(1));
    send_list(t);
    repeat (2) begin
      write_search($urandom_range(0, 1) ? iltm_pkg::VALUE_W'($urandom()) :
                   iltm_pkg::VALUE_W'($urandom_range(0, 99)));
      t.delete();
      while (t.size() < 240) begin
        make_list(part);
        foreach (part[i]) t.push_back(part[i]);
      end
      send_list(t);
    end
  endtask

  task automatic test_random_lists();
    logic [iltm_pkg::VALUE_W-1:0] target;
    while (chars_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 7))
        0:       target = '0;
        1:       target = iltm_pkg::MAG_CAP;
        2:       target = iltm_pkg::MAX_POS;
        3:       target = '1;
        4, 5:    target = iltm_pkg::VALUE_W'(int'($urandom_range(0, 200)) - 100);
        default: target = $urandom();
      endcase
      write_search(target);
      repeat ($urandom_range(4, 12)) begin
        make_list(list_buf);
        send_list(list_buf);
      end
      if (chars_sent > ITEM_GOAL - CALM_TAIL) idling_on = 1'b0;
    end
  endtask

  initial begin
    chr.valid       = 1'b0;
    chr.char_code   = '0;
    chr.is_last     = 1'b0;
    res.ready       = 1'b0;
    search_value_we = 1'b0;
    search_value    = '0;
    want_value      = '0;
    clear_scan();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_special_cases();
    test_char_limit();
    test_random_lists();

    wait_idle();
    repeat (10) @(negedge clk_i);
    $display("tb_top: %0d characters in %0d lists under %0d search values",
             chars_sent, lists_sent, n_settings);
    $display("tb_top: %0d results checked, %0d of them matches, %0d mismatches",
             results_seen, matches_seen, errors);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top: timeout with %0d results still expected", expected_matches.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule
